>>> hw/rtl/sbsi_pkg.sv
// shared types, constants and helpers of the segment box slab intersect unit
package sbsi_pkg;

   // fixed point layout
   localparam int FRAC_BITS = 16;
   localparam int CRD_W     = 32;
   localparam int DIF_W     = CRD_W + 1;
   localparam int MAG_W     = CRD_W;
   localparam int PROD_W    = 2 * MAG_W;
   localparam int EPS_W     = 16;
   localparam int EPRD_W    = EPS_W + MAG_W;
   localparam int PAR_W     = (MAG_W + FRAC_BITS > EPRD_W) ? MAG_W + FRAC_BITS : EPRD_W;
   localparam int WIDE_W    = 64;
   localparam int FACE_W    = 3;

   localparam int NUM_AXES  = 3;
   localparam int NUM_LANES = 2 * NUM_AXES;
   localparam int DIV_STEPS = PROD_W;

   // quotient clamp and the unbounded time marker
   localparam logic [PROD_W-1:0]        QUO_LIM = 64'h2000_0000_0000_0000;
   localparam logic signed [WIDE_W-1:0] T_UNB   = 64'sh2000_0001_0000_0000;

   localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

   typedef logic [FACE_W-1:0] face_type;
   localparam face_type FACE_NONE = 3'd6;

   // register indexes of the configuration port
   typedef enum logic [2:0] {
      CSR_LOW_X  = 3'd0,
      CSR_LOW_Y  = 3'd1,
      CSR_LOW_Z  = 3'd2,
      CSR_HIGH_X = 3'd3,
      CSR_HIGH_Y = 3'd4,
      CSR_HIGH_Z = 3'd5,
      CSR_EPS    = 3'd6
   } csr_idx_type;

   // one restoring division in flight: remainder, dividend bits turning into quotient
   typedef struct packed {
      logic [MAG_W-1:0]  rem;
      logic [PROD_W-1:0] num;
      logic [MAG_W-1:0]  dvs;
      logic              neg;
   } div_lane_type;

   // item context carried beside the divisions
   typedef struct packed {
      logic                               valid;
      logic                               degen;
      logic                               fwd;
      logic [NUM_AXES-1:0]                par;
      logic [CRD_W-1:0]                   t0;
      logic [NUM_AXES-1:0][CRD_W-1:0]     sp;
   } ctx_type;

   // one result beat
   typedef struct packed {
      logic             valid;
      logic             hit;
      logic             degen;
      logic [CRD_W-1:0] entry_time;
      logic [CRD_W-1:0] exit_time;
      face_type         entry_face;
      face_type         exit_face;
   } res_type;

   // sign extension helpers
   function automatic logic signed [DIF_W-1:0] sext(input logic [CRD_W-1:0] v);
      return DIF_W'($signed(v));
   endfunction

   function automatic logic signed [WIDE_W-1:0] wide(input logic [CRD_W-1:0] v);
      return WIDE_W'($signed(v));
   endfunction

endpackage

>>> hw/rtl/sbsi_front.sv
// front pipeline: differences, magnitudes, parallel test, operand select, products
module sbsi_front (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  logic                                                 adv,
   input  logic                                                 in_valid,
   input  logic [sbsi_pkg::NUM_AXES-1:0][sbsi_pkg::CRD_W-1:0]   start_p,
   input  logic [sbsi_pkg::NUM_AXES-1:0][sbsi_pkg::CRD_W-1:0]   end_p,
   input  logic [sbsi_pkg::CRD_W-1:0]                           start_time,
   input  logic [sbsi_pkg::CRD_W-1:0]                           end_time,
   input  logic [sbsi_pkg::NUM_AXES-1:0][sbsi_pkg::CRD_W-1:0]   box_lo,
   input  logic [sbsi_pkg::NUM_AXES-1:0][sbsi_pkg::CRD_W-1:0]   box_hi,
   input  logic [sbsi_pkg::EPS_W-1:0]                           eps,
   output sbsi_pkg::div_lane_type [sbsi_pkg::NUM_LANES-1:0]     lane_out,
   output sbsi_pkg::ctx_type                                    ctx_out
);
   import sbsi_pkg::*;

   typedef struct packed {
      logic                             valid;
      logic                             degen;
      logic                             fwd;
      logic [NUM_AXES-1:0][MAG_W-1:0]   mdp;
      logic [NUM_AXES-1:0][MAG_W-1:0]   mlo;
      logic [NUM_AXES-1:0][MAG_W-1:0]   mhi;
      logic [NUM_AXES-1:0]              ndp;
      logic [NUM_AXES-1:0]              nlo;
      logic [NUM_AXES-1:0]              nhi;
      logic [NUM_AXES-1:0]              zdp;
      logic [MAG_W-1:0]                 mdel;
      logic [MAG_W-1:0]                 mt0;
      logic                             ndel;
      logic                             nt0;
      logic [CRD_W-1:0]                 t0;
      logic [NUM_AXES-1:0][CRD_W-1:0]   sp;
   } prep_type;

   typedef struct packed {
      logic [NUM_LANES-1:0][MAG_W-1:0]  opa;
      logic [NUM_LANES-1:0][MAG_W-1:0]  opb;
      logic [NUM_LANES-1:0][MAG_W-1:0]  dvs;
      logic [NUM_LANES-1:0]             neg;
      ctx_type                          ctx;
   } sel_type;

   function automatic logic [MAG_W-1:0] absmag(input logic signed [DIF_W-1:0] v);
      logic signed [DIF_W-1:0] n;
      n = v[DIF_W-1] ? -v : v;
      return n[MAG_W-1:0];
   endfunction

   // stage a: differences against the start point
   logic signed [DIF_W-1:0]          a_dp_ff  [NUM_AXES];
   logic signed [DIF_W-1:0]          a_dlo_ff [NUM_AXES];
   logic signed [DIF_W-1:0]          a_dhi_ff [NUM_AXES];
   logic signed [DIF_W-1:0]          a_del_ff;
   logic [CRD_W-1:0]                 a_t0_ff;
   logic [NUM_AXES-1:0][CRD_W-1:0]   a_sp_ff;
   logic                             a_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            a_dp_ff[k]  <= sext(end_p[k]) - sext(start_p[k]);
            a_dlo_ff[k] <= sext(box_lo[k]) - sext(start_p[k]);
            a_dhi_ff[k] <= sext(box_hi[k]) - sext(start_p[k]);
         end
         a_del_ff <= sext(end_time) - sext(start_time);
         a_t0_ff  <= start_time;
         a_sp_ff  <= start_p;
      end
   end

   // stage b: magnitudes and signs
   prep_type b_in, b_ff;

   always_comb begin
      b_in.valid = a_valid_ff;
      b_in.degen = (a_del_ff == '0);
      b_in.fwd   = !a_del_ff[DIF_W-1] && (a_del_ff != '0);
      for (int k = 0; k < NUM_AXES; k++) begin
         b_in.mdp[k] = absmag(a_dp_ff[k]);
         b_in.mlo[k] = absmag(a_dlo_ff[k]);
         b_in.mhi[k] = absmag(a_dhi_ff[k]);
         b_in.ndp[k] = a_dp_ff[k][DIF_W-1];
         b_in.nlo[k] = a_dlo_ff[k][DIF_W-1];
         b_in.nhi[k] = a_dhi_ff[k][DIF_W-1];
         b_in.zdp[k] = (a_dp_ff[k] == '0);
      end
      b_in.mdel = absmag(a_del_ff);
      b_in.mt0  = absmag(sext(a_t0_ff));
      b_in.ndel = a_del_ff[DIF_W-1];
      b_in.nt0  = a_t0_ff[CRD_W-1];
      b_in.t0   = a_t0_ff;
      b_in.sp   = a_sp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff.valid <= 1'b0;
      end else if (adv) begin
         b_ff <= b_in;
      end
   end

   // stage c: epsilon times the time span
   prep_type            c_ff;
   logic [EPRD_W-1:0]   c_eprod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff.valid <= 1'b0;
      end else if (adv) begin
         c_ff <= b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_eprod_ff <= eps * b_ff.mdel;
      end
   end

   // stage d: parallel test and division operand select
   logic [PAR_W-1:0]    par_lhs [NUM_AXES];
   logic [NUM_AXES-1:0] par;
   sel_type             d_in, d_ff;

   always_comb begin
      d_in.ctx.valid = c_ff.valid;
      d_in.ctx.degen = c_ff.degen;
      d_in.ctx.fwd   = c_ff.fwd;
      d_in.ctx.t0    = c_ff.t0;
      d_in.ctx.sp    = c_ff.sp;
      for (int k = 0; k < NUM_AXES; k++) begin
         par_lhs[k] = PAR_W'(c_ff.mdp[k]) << FRAC_BITS;
         par[k]     = c_ff.zdp[k] || (par_lhs[k] < PAR_W'(c_eprod_ff));
         // low lane: origin offset on a parallel axis, low plane crossing otherwise
         if (par[k]) begin
            d_in.opa[2*k] = c_ff.mdp[k];
            d_in.opb[2*k] = c_ff.mt0;
            d_in.dvs[2*k] = c_ff.mdel;
            d_in.neg[2*k] = c_ff.ndp[k] ^ c_ff.nt0 ^ c_ff.ndel;
         end else begin
            d_in.opa[2*k] = c_ff.mlo[k];
            d_in.opb[2*k] = c_ff.mdel;
            d_in.dvs[2*k] = c_ff.mdp[k];
            d_in.neg[2*k] = c_ff.nlo[k] ^ c_ff.ndel ^ c_ff.ndp[k];
         end
         // high lane: high plane crossing
         d_in.opa[2*k+1] = c_ff.mhi[k];
         d_in.opb[2*k+1] = c_ff.mdel;
         d_in.dvs[2*k+1] = c_ff.mdp[k];
         d_in.neg[2*k+1] = c_ff.nhi[k] ^ c_ff.ndel ^ c_ff.ndp[k];
      end
      d_in.ctx.par = par;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff.ctx.valid <= 1'b0;
      end else if (adv) begin
         d_ff <= d_in;
      end
   end

   // stage e: dividend products, start of each division
   div_lane_type [NUM_LANES-1:0] e_lane_in, e_lane_ff;
   ctx_type                      e_ctx_ff;

   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         e_lane_in[l].rem = '0;
         e_lane_in[l].num = d_ff.opa[l] * d_ff.opb[l];
         e_lane_in[l].dvs = d_ff.dvs[l];
         e_lane_in[l].neg = d_ff.neg[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_ctx_ff.valid <= 1'b0;
      end else if (adv) begin
         e_ctx_ff <= d_ff.ctx;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_lane_ff <= e_lane_in;
      end
   end

   assign lane_out = e_lane_ff;
   assign ctx_out  = e_ctx_ff;

endmodule

>>> hw/rtl/sbsi_div_cell.sv
// one cell of the divider chain: one quotient bit for every lane
module sbsi_div_cell (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              adv,
   input  sbsi_pkg::div_lane_type [sbsi_pkg::NUM_LANES-1:0]  up_lane,
   input  sbsi_pkg::ctx_type                                 up_ctx,
   output sbsi_pkg::div_lane_type [sbsi_pkg::NUM_LANES-1:0]  dn_lane,
   output sbsi_pkg::ctx_type                                 dn_ctx
);
   import sbsi_pkg::*;

   logic [MAG_W:0]               trial [NUM_LANES];
   logic [MAG_W:0]               diff  [NUM_LANES];
   logic [NUM_LANES-1:0]         fits;
   div_lane_type [NUM_LANES-1:0] lane_in, lane_ff;
   ctx_type                      ctx_ff;

   // restoring step: shift in the next dividend bit, subtract when it fits
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         trial[l] = {up_lane[l].rem, up_lane[l].num[PROD_W-1]};
         diff[l]  = trial[l] - {1'b0, up_lane[l].dvs};
         fits[l]  = (trial[l] >= {1'b0, up_lane[l].dvs});
         lane_in[l].rem = fits[l] ? diff[l][MAG_W-1:0] : trial[l][MAG_W-1:0];
         lane_in[l].num = {up_lane[l].num[PROD_W-2:0], fits[l]};
         lane_in[l].dvs = up_lane[l].dvs;
         lane_in[l].neg = up_lane[l].neg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff.valid <= 1'b0;
      end else if (adv) begin
         ctx_ff <= up_ctx;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lane_ff <= lane_in;
      end
   end

   assign dn_lane = lane_ff;
   assign dn_ctx  = ctx_ff;

endmodule

>>> hw/rtl/sbsi_back.sv
// back pipeline: clamp quotients, crossing times, slab merge, result register
module sbsi_back (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  logic                                                 adv,
   input  sbsi_pkg::div_lane_type [sbsi_pkg::NUM_LANES-1:0]     dn_lane,
   input  sbsi_pkg::ctx_type                                    dn_ctx,
   input  logic [sbsi_pkg::NUM_AXES-1:0][sbsi_pkg::CRD_W-1:0]   box_lo,
   input  logic [sbsi_pkg::NUM_AXES-1:0][sbsi_pkg::CRD_W-1:0]   box_hi,
   output sbsi_pkg::res_type                                    res
);
   import sbsi_pkg::*;

   localparam logic signed [WIDE_W-1:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [WIDE_W-1:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;

   function automatic logic [CRD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] c;
      priority if (v > S32_MAX) c = S32_MAX;
      else if (v < S32_MIN)     c = S32_MIN;
      else                      c = v;
      return c[CRD_W-1:0];
   endfunction

   // stage f: clamp and sign each quotient
   logic [PROD_W-1:0]        qm       [NUM_LANES];
   logic signed [WIDE_W-1:0] f_q_in   [NUM_LANES];
   logic signed [WIDE_W-1:0] f_q_ff   [NUM_LANES];
   ctx_type                  f_ctx_ff;

   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         qm[l]     = (dn_lane[l].num > QUO_LIM) ? QUO_LIM : dn_lane[l].num;
         f_q_in[l] = dn_lane[l].neg ? -$signed(qm[l]) : $signed(qm[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_ctx_ff.valid <= 1'b0;
      end else if (adv) begin
         f_ctx_ff <= dn_ctx;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_q_ff <= f_q_in;
      end
   end

   // stage g: plane crossing times, or origin on a parallel axis
   logic signed [WIDE_W-1:0] g_v0_ff [NUM_AXES];
   logic signed [WIDE_W-1:0] g_v1_ff [NUM_AXES];
   ctx_type                  g_ctx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         g_ctx_ff.valid <= 1'b0;
      end else if (adv) begin
         g_ctx_ff <= f_ctx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            g_v0_ff[k] <= f_ctx_ff.par[k] ? wide(f_ctx_ff.sp[k]) - f_q_ff[2*k]
                                          : wide(f_ctx_ff.t0) + f_q_ff[2*k];
            g_v1_ff[k] <= wide(f_ctx_ff.t0) + f_q_ff[2*k+1];
         end
      end
   end

   // stage h: per axis near and far crossing, parallel slab check
   logic signed [WIDE_W-1:0] h_near_ff  [NUM_AXES];
   logic signed [WIDE_W-1:0] h_far_ff   [NUM_AXES];
   face_type                 h_fnear_ff [NUM_AXES];
   face_type                 h_ffar_ff  [NUM_AXES];
   logic [NUM_AXES-1:0]      h_miss_ff;
   ctx_type                  h_ctx_ff;
   logic [NUM_AXES-1:0]      lt;

   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         lt[k] = g_v0_ff[k] < g_v1_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ctx_ff.valid <= 1'b0;
      end else if (adv) begin
         h_ctx_ff <= g_ctx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            if (g_ctx_ff.par[k]) begin
               h_near_ff[k]  <= -T_UNB;
               h_far_ff[k]   <= T_UNB;
               h_fnear_ff[k] <= FACE_NONE;
               h_ffar_ff[k]  <= FACE_NONE;
               h_miss_ff[k]  <= (g_v0_ff[k] < wide(box_lo[k])) ||
                                (g_v0_ff[k] > wide(box_hi[k]));
            end else begin
               h_near_ff[k]  <= lt[k] ? g_v0_ff[k] : g_v1_ff[k];
               h_far_ff[k]   <= lt[k] ? g_v1_ff[k] : g_v0_ff[k];
               h_fnear_ff[k] <= lt[k] ? face_type'(2*k) : face_type'(2*k+1);
               h_ffar_ff[k]  <= lt[k] ? face_type'(2*k+1) : face_type'(2*k);
               h_miss_ff[k]  <= 1'b0;
            end
         end
      end
   end

   // stage i: merge x and y, a later axis wins only when strictly tighter
   logic signed [WIDE_W-1:0] i_ent_ff, i_ext_ff, i_near2_ff, i_far2_ff;
   face_type                 i_fin_ff, i_fout_ff, i_fnear2_ff, i_ffar2_ff;
   logic                     i_miss_ff;
   ctx_type                  i_ctx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ctx_ff.valid <= 1'b0;
      end else if (adv) begin
         i_ctx_ff <= h_ctx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (h_near_ff[1] > h_near_ff[0]) begin
            i_ent_ff <= h_near_ff[1];
            i_fin_ff <= h_fnear_ff[1];
         end else begin
            i_ent_ff <= h_near_ff[0];
            i_fin_ff <= h_fnear_ff[0];
         end
         if (h_far_ff[1] < h_far_ff[0]) begin
            i_ext_ff  <= h_far_ff[1];
            i_fout_ff <= h_ffar_ff[1];
         end else begin
            i_ext_ff  <= h_far_ff[0];
            i_fout_ff <= h_ffar_ff[0];
         end
         i_near2_ff  <= h_near_ff[2];
         i_far2_ff   <= h_far_ff[2];
         i_fnear2_ff <= h_fnear_ff[2];
         i_ffar2_ff  <= h_ffar_ff[2];
         i_miss_ff   <= |h_miss_ff;
      end
   end

   // stage j: merge z
   logic signed [WIDE_W-1:0] j_ent_ff, j_ext_ff;
   face_type                 j_fin_ff, j_fout_ff;
   logic                     j_miss_ff;
   ctx_type                  j_ctx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         j_ctx_ff.valid <= 1'b0;
      end else if (adv) begin
         j_ctx_ff <= i_ctx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (i_near2_ff > i_ent_ff) begin
            j_ent_ff <= i_near2_ff;
            j_fin_ff <= i_fnear2_ff;
         end else begin
            j_ent_ff <= i_ent_ff;
            j_fin_ff <= i_fin_ff;
         end
         if (i_far2_ff < i_ext_ff) begin
            j_ext_ff  <= i_far2_ff;
            j_fout_ff <= i_ffar2_ff;
         end else begin
            j_ext_ff  <= i_ext_ff;
            j_fout_ff <= i_fout_ff;
         end
         j_miss_ff <= i_miss_ff;
      end
   end

   // stage k: empty interval check, swap for reversed time, saturate
   logic     miss, swap;
   res_type  res_in, res_ff;

   always_comb begin
      miss = j_miss_ff || (j_ent_ff > j_ext_ff);
      swap = !j_ctx_ff.fwd && (j_ent_ff < j_ext_ff);
      res_in.valid      = j_ctx_ff.valid;
      res_in.degen      = j_ctx_ff.degen;
      res_in.hit        = 1'b0;
      res_in.entry_time = '0;
      res_in.exit_time  = '0;
      res_in.entry_face = FACE_NONE;
      res_in.exit_face  = FACE_NONE;
      if (!j_ctx_ff.degen && !miss) begin
         res_in.hit        = 1'b1;
         res_in.entry_time = swap ? sat32(j_ext_ff) : sat32(j_ent_ff);
         res_in.exit_time  = swap ? sat32(j_ent_ff) : sat32(j_ext_ff);
         res_in.entry_face = swap ? j_fout_ff : j_fin_ff;
         res_in.exit_face  = swap ? j_fin_ff : j_fout_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff.valid <= 1'b0;
      end else if (adv) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

>>> hw/rtl/segment_box_slab_intersect_unit.sv
// top level of the segment versus axis-aligned box slab intersection unit
//
// Tests a timed ray segment against the box held in the configuration
// registers, all values signed Q16.16. One item is accepted per cycle while
// req_tready is high and one result beat leaves per item, in order. An item
// passes 5 front stages (differences, magnitudes, epsilon product, parallel
// test and operand select, 32x32 products), a chain of 64 divider cells that
// each retire one quotient bit of all six divisions, and 6 back stages
// (clamp, crossing times, slab check, two merge stages, result register).
// When rsp_tready is low with a result waiting the whole pipe holds and
// req_tready drops. Box and epsilon writes reach items accepted after the
// write and some in flight; write them only while no item is in flight.
module segment_box_slab_intersect_unit (
   input  logic         clock,
   input  logic         reset,
   // input beats
   input  logic         req_tvalid,
   output logic         req_tready,
   // start_x, start_y, start_z, end_x, end_y, end_z, start_time, end_time
   input  logic [255:0] req_tdata,
   // result beats
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // hit, degenerate, entry_time, exit_time, entry_face, exit_face
   output logic [71:0]  rsp_tdata,
   // configuration writes
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);
   import sbsi_pkg::*;

   // configuration registers
   logic [NUM_AXES-1:0][CRD_W-1:0] box_lo_ff, box_hi_ff;
   logic [EPS_W-1:0]               eps_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_lo_ff <= '0;
         box_hi_ff <= '0;
         eps_ff    <= EPS_RESET;
      end else if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_LOW_X:  box_lo_ff[0] <= csr_data;
            CSR_LOW_Y:  box_lo_ff[1] <= csr_data;
            CSR_LOW_Z:  box_lo_ff[2] <= csr_data;
            CSR_HIGH_X: box_hi_ff[0] <= csr_data;
            CSR_HIGH_Y: box_hi_ff[1] <= csr_data;
            CSR_HIGH_Z: box_hi_ff[2] <= csr_data;
            CSR_EPS:    eps_ff       <= csr_data[EPS_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline moves whenever the result register is free or being taken
   res_type res;
   logic    adv;

   assign adv        = !res.valid || rsp_tready;
   assign req_tready = adv;

   // unpack the input beat
   logic [NUM_AXES-1:0][CRD_W-1:0] start_p, end_p;
   logic [CRD_W-1:0]               start_time, end_time;

   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         start_p[k] = req_tdata[k*CRD_W +: CRD_W];
         end_p[k]   = req_tdata[(NUM_AXES+k)*CRD_W +: CRD_W];
      end
   end

   assign start_time = req_tdata[2*NUM_AXES*CRD_W +: CRD_W];
   assign end_time   = req_tdata[(2*NUM_AXES+1)*CRD_W +: CRD_W];

   // front stages
   div_lane_type [NUM_LANES-1:0] chain_lane [DIV_STEPS+1];
   ctx_type                      chain_ctx  [DIV_STEPS+1];

   sbsi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (req_tvalid),
      .start_p    (start_p),
      .end_p      (end_p),
      .start_time (start_time),
      .end_time   (end_time),
      .box_lo     (box_lo_ff),
      .box_hi     (box_hi_ff),
      .eps        (eps_ff),
      .lane_out   (chain_lane[0]),
      .ctx_out    (chain_ctx[0])
   );

   // divider chain, one quotient bit per cell
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      sbsi_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .up_lane (chain_lane[i]),
         .up_ctx  (chain_ctx[i]),
         .dn_lane (chain_lane[i+1]),
         .dn_ctx  (chain_ctx[i+1])
      );
   end

   // back stages and result register
   sbsi_back u_back (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .dn_lane (chain_lane[DIV_STEPS]),
      .dn_ctx  (chain_ctx[DIV_STEPS]),
      .box_lo  (box_lo_ff),
      .box_hi  (box_hi_ff),
      .res     (res)
   );

   assign rsp_tvalid = res.valid;
   assign rsp_tdata  = {res.exit_face, res.entry_face, res.exit_time, res.entry_time,
                        res.degen, res.hit};

endmodule

>>> test/tb_top.sv
// testbench of the segment box slab intersect unit: random and directed rays, scoreboard check
module tb_top;
   import sbsi_pkg::*;

   localparam int  GAP_LONG    = 60;
   localparam int  DRAIN_WAIT  = 100;
   localparam int  WATCH_LIMIT = 20000;
   localparam int  NUM_PHASES  = 10;
   localparam int  PHASE_ITEMS = 200;
   localparam longint SLAB_LIM = 64'sh2000_0000_0000_0000;
   localparam longint UNBOUND  = 64'sh2000_0001_0000_0000;
   localparam logic [31:0] ONE = 32'h0001_0000;

   // expected outcome of one ray
   typedef struct packed {
      bit          hit;
      bit          degen;
      bit [31:0]   entry_t;
      bit [31:0]   exit_t;
      face_type    entry_f;
      face_type    exit_f;
   } ray_verdict_type;

   // predicts the unit and checks its results in order
   class slab_scoreboard;
      longint          box_lo[3];
      longint          box_hi[3];
      longint          eps = 1;
      ray_verdict_type pending[$];
      int              n_fail = 0;
      int              n_checked = 0;
      int              n_hits = 0;
      int              n_degen = 0;

      function void write_reg(csr_idx_type idx, logic [31:0] val);
         if (idx <= CSR_LOW_Z) box_lo[idx] = longint'($signed(val));
         else if (idx <= CSR_HIGH_Z) box_hi[idx - CSR_HIGH_X] = longint'($signed(val));
         else if (idx == CSR_EPS) eps = longint'(val[15:0]);
      endfunction

      // trunc(x*y/z) clamped to the slab limit
      static function longint scale_div(longint x, longint y, longint z);
         logic [127:0] p, q;
         logic [63:0]  a, b, d;
         bit           neg;
         a = x < 0 ? -x : x;
         b = y < 0 ? -y : y;
         d = z < 0 ? -z : z;
         neg = ((x < 0) != (y < 0)) != (z < 0);
         if (d == 0) return 0;
         p = {64'b0, a} * {64'b0, b};
         q = p / {64'b0, d};
         if (q > 128'(SLAB_LIM)) q = 128'(SLAB_LIM);
         return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
      endfunction

      static function bit [31:0] clip32(longint v);
         if (v > 64'sd2147483647) v = 64'sd2147483647;
         if (v < -64'sd2147483648) v = -64'sd2147483648;
         return v[31:0];
      endfunction

      function ray_verdict_type slab_test(logic [255:0] d);
         ray_verdict_type r;
         longint s[3], e[3], t0, t1, dt, entry, leave, dp, ta, tb, tmp, mdp, mdt;
         face_type fin, fout, ft;
         bit par;
         for (int k = 0; k < 3; k++) begin
            s[k] = longint'($signed(d[32*k +: 32]));
            e[k] = longint'($signed(d[32*(k+3) +: 32]));
         end
         t0 = longint'($signed(d[223:192]));
         t1 = longint'($signed(d[255:224]));
         dt = t1 - t0;
         r = '{0, 0, 0, 0, FACE_NONE, FACE_NONE};
         if (dt == 0) begin
            r.degen = 1;
            return r;
         end
         fin = FACE_NONE;
         fout = FACE_NONE;
         entry = -UNBOUND;
         leave = UNBOUND;
         for (int k = 0; k < 3; k++) begin
            dp = e[k] - s[k];
            mdp = dp < 0 ? -dp : dp;
            mdt = dt < 0 ? -dt : dt;
            par = (dp == 0) || ((mdp <<< FRAC_BITS) < eps * mdt);
            if (par) begin
               tmp = s[k] - scale_div(dp, t0, dt);
               if (tmp < box_lo[k] || tmp > box_hi[k]) return r;
            end else begin
               ta = t0 + scale_div(box_lo[k] - s[k], dt, dp);
               tb = t0 + scale_div(box_hi[k] - s[k], dt, dp);
               if (ta < tb) begin
                  if (ta > entry) begin entry = ta; fin = face_type'(2*k); end
                  if (tb < leave) begin leave = tb; fout = face_type'(2*k+1); end
               end else begin
                  if (tb > entry) begin entry = tb; fin = face_type'(2*k+1); end
                  if (ta < leave) begin leave = ta; fout = face_type'(2*k); end
               end
               if (entry > leave) return r;
            end
         end
         // reversed time order swaps the interval ends
         if ((t0 < t1) ? (entry > leave) : (entry < leave)) begin
            tmp = entry; entry = leave; leave = tmp;
            ft = fin; fin = fout; fout = ft;
         end
         r.hit = 1;
         r.entry_t = clip32(entry);
         r.exit_t = clip32(leave);
         r.entry_f = fin;
         r.exit_f = fout;
         return r;
      endfunction

      function void note_ray(logic [255:0] d);
         pending.push_back(slab_test(d));
      endfunction

      function void check_result(logic [71:0] d);
         ray_verdict_type x, a;
         a.hit = d[0];
         a.degen = d[1];
         a.entry_t = d[33:2];
         a.exit_t = d[65:34];
         a.entry_f = d[68:66];
         a.exit_f = d[71:69];
         if (pending.size() == 0) begin
            n_fail++;
            if (n_fail <= 10) $display("unexpected result beat %h", d);
            return;
         end
         x = pending.pop_front();
         n_checked++;
         n_hits += a.hit;
         n_degen += a.degen;
         if (a != x) begin
            n_fail++;
            if (n_fail <= 10) begin
               $display("result %0d mismatch: exp hit=%b deg=%b in=%h out=%h f=%0d/%0d",
                  n_checked, x.hit, x.degen, x.entry_t, x.exit_t, x.entry_f, x.exit_f);
               $display("   got hit=%b deg=%b in=%h out=%h f=%0d/%0d",
                  a.hit, a.degen, a.entry_t, a.exit_t, a.entry_f, a.exit_f);
            end
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [255:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [71:0]  rsp_tdata;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [31:0]  csr_data = '0;

   slab_scoreboard sb = new;
   int  idle_cycles = 0;
   int  n_sent = 0;
   bit  stall_on = 1;
   bit  gaps_on = 1;

   segment_box_slab_intersect_unit uut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // monitor all beats at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_idx_type'(csr_index), csr_data);
         if (req_tvalid && req_tready) sb.note_ray(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if ((csr_valid && csr_ready) || (req_tvalid && req_tready)
             || (rsp_tvalid && rsp_tready)
             || (sb.pending.size() == 0 && !req_tvalid && !csr_valid))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCH_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCH_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, GAP_LONG);
   endfunction

   // result side stalls
   initial begin
      int n;
      forever begin
         @(negedge clock);
         n = stall_on ? pick_gap() : 0;
         if (n == 0) rsp_tready <= 1;
         else begin
            rsp_tready <= 0;
            repeat (n - 1) @(negedge clock);
         end
      end
   end

   task automatic write_csr(csr_idx_type idx, logic [31:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic set_box(logic [31:0] lx, ly, lz, hx, hy, hz, logic [15:0] e);
      write_csr(CSR_LOW_X, lx);
      write_csr(CSR_LOW_Y, ly);
      write_csr(CSR_LOW_Z, lz);
      write_csr(CSR_HIGH_X, hx);
      write_csr(CSR_HIGH_Y, hy);
      write_csr(CSR_HIGH_Z, hz);
      write_csr(CSR_EPS, {16'b0, e});
   endtask

   task automatic send_ray(logic [31:0] sx, sy, sz, ex, ey, ez, t0, t1);
      int g;
      req_tvalid <= 1;
      req_tdata <= {t1, t0, ez, ey, ex, sz, sy, sx};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      n_sent++;
      g = gaps_on ? pick_gap() : 0;
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [31:0] near_crd(int span);
      return 32'($urandom_range(0, 2 * span * 65536) - span * 65536);
   endfunction

   // mostly well-formed rays near the box, some raw noise
   task automatic send_random_ray();
      logic [31:0] s[3], e[3], t0, t1;
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom);
         return;
      end
      for (int k = 0; k < 3; k++) begin
         s[k] = near_crd(32);
         case ($urandom_range(0, 9))
            0: e[k] = s[k];
            1: e[k] = s[k] + 32'($urandom_range(0, 3)) - 32'd1;
            default: e[k] = near_crd(32);
         endcase
      end
      t0 = near_crd(4);
      case ($urandom_range(0, 19))
         0: t1 = t0;
         1: t1 = $urandom;
         default: t1 = t0 + ($urandom_range(0, 1) ? ONE : -ONE) * $urandom_range(1, 3)
                       + $urandom_range(0, 65535);
      endcase
      send_ray(s[0], s[1], s[2], e[0], e[1], e[2], t0, t1);
   endtask

   initial begin
      logic [31:0] lo[3], hi[3];
      logic [15:0] e;
      int mode;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed rays against a box of half size four
      set_box(-4 * ONE, -4 * ONE, -4 * ONE, 4 * ONE, 4 * ONE, 4 * ONE, 16'h0100);
      send_ray(-8 * ONE, 0, 0, 8 * ONE, 0, 0, 0, ONE);                 // through along x
      send_ray(-8 * ONE, ONE, -ONE, 8 * ONE, 2 * ONE, ONE, 0, ONE);    // oblique hit
      send_ray(-8 * ONE, 9 * ONE, 0, 8 * ONE, 9 * ONE, 0, 0, ONE);     // parallel axis outside
      send_ray(-8 * ONE, -8 * ONE, 0, 8 * ONE, 8 * ONE, 9 * ONE, 0, ONE);
      send_ray(ONE, ONE, ONE, 5 * ONE, 6 * ONE, 7 * ONE, ONE, ONE);    // equal times
      send_ray(-8 * ONE, 0, 0, 8 * ONE, 0, 0, ONE, 0);                 // reversed time order
      send_ray(0, 0, 0, 0, 0, 0, 0, ONE);                              // all parallel inside
      send_ray(ONE, ONE, ONE, ONE + 1, ONE, ONE, 0, ONE);              // slow axis counts parallel
      send_ray(-4 * ONE, -4 * ONE, 0, 4 * ONE, 4 * ONE, 0, 0, ONE);    // corner ties
      send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      send_ray(32'h7fff_ffff, 0, 0, 32'h8000_0000, 0, 0, 32'h7fff_ffff, 32'h8000_0000);
      send_ray(-8 * ONE, 0, 0, 8 * ONE, 0, 0, 0, 1);                   // huge speed
      send_ray(-8 * ONE, 0, 0, -8 * ONE + 1, 0, 0, 32'h8000_0000, 32'h7fff_ffff);
      drain();
      set_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'h0000);
      send_ray(ONE, ONE, ONE, ONE + 1, ONE, ONE, 0, ONE);              // zero epsilon
      send_ray(0, 0, 0, 0, 0, 0, 32'h8000_0000, 32'h7fff_ffff);
      send_ray(32'h8000_0000, 0, 0, 32'h7fff_ffff, 0, 0, 0, 1);
      drain();
      set_box(4 * ONE, ONE, ONE, -4 * ONE, -ONE, -ONE, 16'hffff);      // inverted box
      send_ray(-8 * ONE, 0, 0, 8 * ONE, 0, 0, 0, ONE);
      send_ray(0, 0, 0, 0, 0, 0, 0, ONE);
      send_ray(-8 * ONE, -ONE, 0, 8 * ONE, ONE, 0, 0, 32'h7fff_ffff);
      drain();

      // random phases, each with fresh register values
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         mode = $urandom_range(0, 5);
         for (int k = 0; k < 3; k++) begin
            case (mode)
               0: begin lo[k] = 32'h8000_0000; hi[k] = 32'h7fff_ffff; end
               1: begin lo[k] = $urandom; hi[k] = $urandom; end
               default: begin
                  lo[k] = near_crd(8);
                  hi[k] = $urandom_range(0, 9) == 0 ? lo[k] - near_crd(2)
                                                    : lo[k] + 32'($urandom_range(0, 16 * 65536));
               end
            endcase
         end
         case ($urandom_range(0, 3))
            0: e = 16'h0000;
            1: e = 16'hffff;
            default: e = 16'($urandom);
         endcase
         set_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], e);
         gaps_on = (ph % 3) != 1;
         stall_on = (ph % 4) != 2;
         for (int i = 0; i < PHASE_ITEMS; i++) send_random_ray();
         drain();
      end

      // let the pipeline settle before the verdict
      stall_on = 1;
      repeat (DRAIN_WAIT) @(negedge clock);
      $display("sent %0d rays over %0d box settings, %0d results checked",
               n_sent, NUM_PHASES + 3, sb.n_checked);
      $display("hits %0d, degenerate %0d, failures %0d", sb.n_hits, sb.n_degen, sb.n_fail);
      if (sb.n_fail == 0 && sb.pending.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
